// File: hdl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg - shared types for the sorted priority queue
// operation and status codes, cell command struct, register constants
// ----------------------------------------------------------------------------
package spq_pkg;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_cmd_t;

	localparam int CFG_W       = 5;
	localparam int LIMIT_RESET = 16;

endpackage
`default_nettype wire

// File: hdl/spq_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ifs - channel interfaces of the sorted priority queue
// item, result and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface spq_item_if #(
	parameter int KEY_BITS     = 16,
	parameter int PAYLOAD_BITS = 8
);
	logic                    valid;
	logic                    ready;
	logic                    operation;
	logic [KEY_BITS-1:0]     key;
	logic [PAYLOAD_BITS-1:0] payload;

	modport source (output valid, operation, key, payload, input ready);
	modport sink   (input valid, operation, key, payload, output ready);
endinterface

interface spq_result_if #(
	parameter int KEY_BITS     = 16,
	parameter int PAYLOAD_BITS = 8,
	parameter int CNT_W        = 5
);
	logic                    valid;
	logic                    ready;
	logic                    out_valid;
	logic [KEY_BITS-1:0]     out_key;
	logic [PAYLOAD_BITS-1:0] out_payload;
	logic [CNT_W-1:0]        occupancy;
	logic                    is_full;
	logic                    is_empty;
	logic [1:0]              status;

	modport source (output valid, out_valid, out_key, out_payload, occupancy,
		is_full, is_empty, status, input ready);
	modport sink   (input valid, out_valid, out_key, out_payload, occupancy,
		is_full, is_empty, status, output ready);
endinterface

interface spq_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: hdl/spq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell - one slot of the sorted chain
// holds, takes the new entry, or shifts from a neighbor
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
#(
	parameter int KEY_BITS     = 16,
	parameter int PAYLOAD_BITS = 8
) (
	input  wire logic                    clk,
	input  wire cell_cmd_t               cmd,
	input  wire logic                    occupied,
	input  wire logic [KEY_BITS-1:0]     new_key,
	input  wire logic [PAYLOAD_BITS-1:0] new_payload,
	input  wire logic                    left_stay,
	input  wire logic [KEY_BITS-1:0]     left_key,
	input  wire logic [PAYLOAD_BITS-1:0] left_payload,
	input  wire logic [KEY_BITS-1:0]     right_key,
	input  wire logic [PAYLOAD_BITS-1:0] right_payload,
	output logic                         stay,
	output logic [KEY_BITS-1:0]          key,
	output logic [PAYLOAD_BITS-1:0]      payload
);

	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] payload_q;

	// equal keys stay ahead of the new entry
	assign stay    = occupied && (key_q <= new_key);
	assign key     = key_q;
	assign payload = payload_q;

	always_ff @(posedge clk) begin
		if (cmd.rem) begin
			key_q     <= right_key;
			payload_q <= right_payload;
		end else if (cmd.ins && !stay) begin
			if (left_stay) begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end else begin
				key_q     <= left_key;
				payload_q <= left_payload;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/sorted_priority_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit - bounded priority queue, ascending keys
// chain of cells kept sorted; insert places a word, remove pops the front
// ----------------------------------------------------------------------------
//  channel   | dir | carries
//  ----------+-----+------------------------------------------------------
//  item_in   | in  | operation, key, payload
//  result_out| out | out_valid, out_key, out_payload, occupancy, flags, status
//  cfg       | in  | capacity limit (5 bits)
//
//  one item per cycle: every cell compares its key with the incoming key
//  in parallel and shifts in the same cycle; the result word is held in
//  one output register that the next item may overwrite as it is taken.
//  stalls: item_in is ready while the result register is empty or drained.
//  reset clears occupancy and sets the limit; cell contents need no reset.
//  cfg is always ready and takes effect on the next item.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
	import spq_pkg::*;
#(
	parameter int CAPACITY     = 16,
	parameter int KEY_BITS     = 16,
	parameter int PAYLOAD_BITS = 8
) (
	input wire logic  clk,
	input wire logic  arst_n,
	spq_item_if.sink  item_in,
	spq_result_if.source result_out,
	spq_cfg_if.sink   cfg
);

	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int LIM_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int LIM_RESET = (CAPACITY < LIMIT_RESET) ? CAPACITY : LIMIT_RESET;

	// occupancy and effective limit
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] limit_q;
	logic [CNT_W-1:0] count_next;

	// result register
	logic                    res_valid_q;
	logic                    out_valid_q;
	logic [KEY_BITS-1:0]     out_key_q;
	logic [PAYLOAD_BITS-1:0] out_payload_q;
	logic [CNT_W-1:0]        occupancy_q;
	logic                    is_full_q;
	logic                    is_empty_q;
	status_t                 status_q;

	logic      accept;
	logic      full;
	logic      empty;
	cell_cmd_t cmd;
	status_t   status_next;
	logic [LIM_W-1:0] cfg_lim;
	logic [CNT_W-1:0] cfg_lim_eff;

	// cell chain wiring
	logic                    stay_w    [CAPACITY];
	logic [KEY_BITS-1:0]     key_w     [CAPACITY];
	logic [PAYLOAD_BITS-1:0] payload_w [CAPACITY];

	assign item_in.ready = !res_valid_q || result_out.ready;
	assign cfg.ready     = 1'b1;
	assign accept        = item_in.valid && item_in.ready;

	assign full  = (count_q >= limit_q);
	assign empty = (count_q == '0);

	always_comb begin
		cmd.ins     = 1'b0;
		cmd.rem     = 1'b0;
		status_next = ST_OK;
		count_next  = count_q;
		if (accept) begin
			if (item_in.operation == OP_INSERT) begin
				if (full) begin
					status_next = ST_FULL;
				end else begin
					cmd.ins    = 1'b1;
					count_next = count_q + CNT_W'(1);
				end
			end else begin
				if (empty) begin
					status_next = ST_EMPTY;
				end else begin
					cmd.rem    = 1'b1;
					count_next = count_q - CNT_W'(1);
				end
			end
		end
	end

	// clamp the written limit into 1..CAPACITY
	assign cfg_lim = LIM_W'(cfg.data);
	always_comb begin
		if (cfg_lim == '0) begin
			cfg_lim_eff = CNT_W'(1);
		end else if (cfg_lim > LIM_W'(CAPACITY)) begin
			cfg_lim_eff = CNT_W'(CAPACITY);
		end else begin
			cfg_lim_eff = CNT_W'(cfg_lim);
		end
	end

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic                    l_stay;
			logic [KEY_BITS-1:0]     l_key;
			logic [PAYLOAD_BITS-1:0] l_payload;
			logic [KEY_BITS-1:0]     r_key;
			logic [PAYLOAD_BITS-1:0] r_payload;

			if (i == 0) begin : g_head
				// front cell sees the new entry as its left neighbor
				assign l_stay    = 1'b0;
				assign l_key     = item_in.key;
				assign l_payload = item_in.payload;
			end else begin : g_mid
				assign l_stay    = stay_w[i-1];
				assign l_key     = key_w[i-1];
				assign l_payload = payload_w[i-1];
			end

			if (i == CAPACITY - 1) begin : g_tail
				assign r_key     = key_w[i];
				assign r_payload = payload_w[i];
			end else begin : g_body
				assign r_key     = key_w[i+1];
				assign r_payload = payload_w[i+1];
			end

			spq_cell #(
				.KEY_BITS     (KEY_BITS),
				.PAYLOAD_BITS (PAYLOAD_BITS)
			) u_cell (
				.clk           (clk),
				.cmd           (cmd),
				.occupied      (count_q > CNT_W'(i)),
				.new_key       (item_in.key),
				.new_payload   (item_in.payload),
				.left_stay     (l_stay),
				.left_key      (l_key),
				.left_payload  (l_payload),
				.right_key     (r_key),
				.right_payload (r_payload),
				.stay          (stay_w[i]),
				.key           (key_w[i]),
				.payload       (payload_w[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			limit_q     <= CNT_W'(LIM_RESET);
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (cfg.valid) begin
				limit_q <= cfg_lim_eff;
			end
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			out_valid_q   <= cmd.rem;
			out_key_q     <= cmd.rem ? key_w[0] : '0;
			out_payload_q <= cmd.rem ? payload_w[0] : '0;
			occupancy_q   <= count_next;
			is_full_q     <= (count_next >= limit_q);
			is_empty_q    <= (count_next == '0);
			status_q      <= status_next;
		end
	end

	assign result_out.valid       = res_valid_q;
	assign result_out.out_valid   = out_valid_q;
	assign result_out.out_key     = out_key_q;
	assign result_out.out_payload = out_payload_q;
	assign result_out.occupancy   = occupancy_q;
	assign result_out.is_full     = is_full_q;
	assign result_out.is_empty    = is_empty_q;
	assign result_out.status      = status_q;

endmodule
`default_nettype wire

// File: dv/spq_result_checker.sv
// ----------------------------------------------------------------------------
// spq_result_checker - result predictor and comparator for the priority queue
// watches the item, result and config channels, keeps its own sorted copy of
// the queue, and compares every result word field by field in order
// ----------------------------------------------------------------------------
module spq_result_checker
	import spq_pkg::*;
#(
	parameter int CAPACITY     = 16,
	parameter int KEY_BITS     = 16,
	parameter int PAYLOAD_BITS = 8,
	parameter int CNT_W        = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	spq_item_if      item_mon,
	spq_result_if    result_mon,
	spq_cfg_if       cfg_mon,
	output int       mismatches,
	output int       outstanding
);

	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic                    removed;
		logic [KEY_BITS-1:0]     key;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [CNT_W-1:0]        occupancy;
		logic                    full;
		logic                    empty;
		status_t                 status;
	} queue_word_t;

	// sorted copy of the queue, front first
	logic [KEY_BITS-1:0]     held_key     [CAPACITY];
	logic [PAYLOAD_BITS-1:0] held_payload [CAPACITY];
	int                      held_count;
	logic [CFG_W-1:0]        limit_reg;
	queue_word_t             due_words [$];
	queue_word_t             seen_word;

	// zero reads as one, anything above the built size as the built size
	function automatic int limit_in_force();
		if (limit_reg == '0)
			return 1;
		if (int'(limit_reg) > CAPACITY)
			return CAPACITY;
		return int'(limit_reg);
	endfunction

	function automatic queue_word_t apply_queue_op(op_t op, logic [KEY_BITS-1:0] k,
		logic [PAYLOAD_BITS-1:0] p);
		queue_word_t w;
		int          lim;
		int          pos;
		w   = '0;
		lim = limit_in_force();
		if (op == OP_INSERT) begin
			if (held_count >= lim) begin
				w.status = ST_FULL;
			end else begin
				// new entry goes behind every key less than or equal to it
				pos = 0;
				while (pos < held_count && held_key[pos] <= k)
					pos++;
				for (int i = held_count; i > pos; i--) begin
					held_key[i]     = held_key[i-1];
					held_payload[i] = held_payload[i-1];
				end
				held_key[pos]     = k;
				held_payload[pos] = p;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				w.status = ST_EMPTY;
			end else begin
				w.removed = 1'b1;
				w.key     = held_key[0];
				w.payload = held_payload[0];
				for (int i = 1; i < held_count; i++) begin
					held_key[i-1]     = held_key[i];
					held_payload[i-1] = held_payload[i];
				end
				held_count--;
			end
		end
		w.occupancy = CNT_W'(held_count);
		w.full      = (held_count >= lim);
		w.empty     = (held_count == 0);
		return w;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t spq mismatch: %s got %0h want %0h", $time, what, got, want);
	endtask

	task automatic compare_word(queue_word_t got, queue_word_t want);
		if (got.removed !== want.removed)
			report("out_valid", 32'(got.removed), 32'(want.removed));
		if (got.key !== want.key)
			report("out_key", 32'(got.key), 32'(want.key));
		if (got.payload !== want.payload)
			report("out_payload", 32'(got.payload), 32'(want.payload));
		if (got.occupancy !== want.occupancy)
			report("occupancy", 32'(got.occupancy), 32'(want.occupancy));
		if (got.full !== want.full)
			report("is_full", 32'(got.full), 32'(want.full));
		if (got.empty !== want.empty)
			report("is_empty", 32'(got.empty), 32'(want.empty));
		if (got.status !== want.status)
			report("status", 32'(got.status), 32'(want.status));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			limit_reg  = CFG_W'(LIMIT_RESET);
			mismatches = 0;
			due_words.delete();
			outstanding <= 0;
		end else begin
			if (result_mon.valid && result_mon.ready) begin
				seen_word = {result_mon.out_valid, result_mon.out_key, result_mon.out_payload,
					result_mon.occupancy, result_mon.is_full, result_mon.is_empty,
					status_t'(result_mon.status)};
				if (due_words.size() == 0)
					report("result word with none due", 32'(seen_word.occupancy), 32'h0);
				else
					compare_word(seen_word, due_words.pop_front());
			end
			if (cfg_mon.valid && cfg_mon.ready)
				limit_reg = cfg_mon.data;
			if (item_mon.valid && item_mon.ready)
				due_words.push_back(apply_queue_op(op_t'(item_mon.operation), item_mon.key,
					item_mon.payload));
			outstanding <= due_words.size();
		end
	end

endmodule

// File: dv/tb_sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_unit - testbench for the sorted priority queue
// directed inserts and removes at the key extremes, ties, empty and full
// cases and odd limits, then random phases under several capacity limits
// with bursty items and a stalling result side; the checker scores words
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_unit;
	import spq_pkg::*;

	localparam int CAPACITY        = 16;
	localparam int KEY_BITS        = 16;
	localparam int PAYLOAD_BITS    = 8;
	localparam int RESET_CYCLES    = 7;
	localparam int SETTLE_CYCLES   = 4;    // one output register, a few spare
	localparam int HOLD_CYCLES     = 64;   // long result-side hold for back pressure
	localparam int WATCHDOG_LIMIT  = 2000; // cycles with no word moving anywhere
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 70;

	// capacity limit and share of inserts (percent) per random phase
	localparam logic [CFG_W-1:0] LIMIT_PLAN [PHASES] =
		'{5'd16, 5'd31, 5'd1, 5'd16, 5'd0, 5'd9, 5'd16, 5'd3, 5'd17, 5'd16};
	localparam int FILL_PLAN [PHASES] = '{80, 30, 60, 50, 70, 20, 75, 50, 60, 40};

	typedef enum int {
		RX_STEADY,
		RX_PATTERN,
		RX_SPARSE
	} rx_mode_t;

	logic clk;
	logic arst_n;

	spq_item_if   #(.KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) item_ch ();
	spq_result_if #(.KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) result_ch ();
	spq_cfg_if cfg_ch ();

	int       mismatch_total;
	int       results_due;
	int       idle_cycles;
	int       burst_left;
	bit       sender_gaps_on;
	bit       hold_req;
	rx_mode_t rx_mode;
	logic [7:0] stall_pattern;

	sorted_priority_queue_unit #(
		.CAPACITY    (CAPACITY),
		.KEY_BITS    (KEY_BITS),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (item_ch),
		.result_out(result_ch),
		.cfg       (cfg_ch)
	);

	spq_result_checker #(
		.CAPACITY    (CAPACITY),
		.KEY_BITS    (KEY_BITS),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_mon   (item_ch),
		.result_mon (result_ch),
		.cfg_mon    (cfg_ch),
		.mismatches (mismatch_total),
		.outstanding(results_due)
	);

	// free-running clock, period 8
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// key mix: mostly anything, a narrow band for ties, and the extremes
	function automatic logic [KEY_BITS-1:0] pick_key();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return KEY_BITS'($urandom);
		if (roll < 8)
			return KEY_BITS'($urandom_range(0, 7));
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			default: return 16'h7FFF;
		endcase
	endfunction

	// offer one item word and return at the edge that takes it
	// a new burst may start with a gap; valid stays high inside a burst
	task automatic send_item(op_t op, logic [KEY_BITS-1:0] k, logic [PAYLOAD_BITS-1:0] p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (!sender_gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_ch.valid     <= 1'b1;
		item_ch.operation <= op;
		item_ch.key       <= k;
		item_ch.payload   <= p;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	// stop offering and let every due result word come back
	// the count is read after the next edge, so the last item is already in it
	task automatic wait_results_drained();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// limit writes only with the queue idle
	task automatic write_limit(logic [CFG_W-1:0] value);
		wait_results_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// result side: steady, rotating stall pattern, or mostly stalled
	// a hold request parks ready low for a long stretch counted here
	initial begin
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			case (rx_mode)
				RX_STEADY: begin
					result_ch.ready <= 1'b1;
				end
				RX_PATTERN: begin
					result_ch.ready <= stall_pattern[0];
					stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
				end
				default: begin
					result_ch.ready <= ($urandom_range(0, 3) == 0);
				end
			endcase
		end
	end

	// watchdog: any word moving on any channel resets the count
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_sorted_priority_queue_unit: errors");
			$finish;
		end
	end

	initial begin
		op_t op;
		// every input known from time zero
		arst_n            <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.operation <= OP_INSERT;
		item_ch.key       <= '0;
		item_ch.payload   <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.data       <= '0;
		hold_req       = 1'b0;
		burst_left     = 0;
		sender_gaps_on = 1'b1;
		rx_mode        = RX_PATTERN;
		stall_pattern  = 8'b1011_0110;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// remove from an empty queue, with all-ones in the ignored fields
		send_item(OP_REMOVE, 16'hFFFF, 8'hFF);
		// key extremes and the sign-bit neighbors
		send_item(OP_INSERT, 16'h0000, 8'h00);
		send_item(OP_INSERT, 16'hFFFF, 8'hFF);
		send_item(OP_INSERT, 16'h8000, 8'h55);
		send_item(OP_INSERT, 16'h7FFF, 8'hAA);
		// equal keys must leave in arrival order
		send_item(OP_INSERT, 16'h1234, 8'h01);
		send_item(OP_INSERT, 16'h1234, 8'h02);
		send_item(OP_INSERT, 16'h1234, 8'h03);
		// drain all seven, then one more from empty
		repeat (8) send_item(OP_REMOVE, 16'h0000, 8'h00);

		// a zero limit acts as one: second insert is dropped
		write_limit(5'd0);
		send_item(OP_INSERT, 16'h00FF, 8'h80);
		send_item(OP_INSERT, 16'h0001, 8'h7F);
		send_item(OP_REMOVE, 16'h0000, 8'h00);

		// limit dropped below the occupancy: entries stay, inserts bounce
		write_limit(5'd16);
		repeat (4) send_item(OP_INSERT, pick_key(), PAYLOAD_BITS'($urandom_range(0, 255)));
		write_limit(5'd2);
		send_item(OP_INSERT, 16'h0000, 8'h00);
		send_item(OP_REMOVE, 16'h0000, 8'h00);

		// random phases: each with its own limit, insert share and idling
		for (int phase = 0; phase < PHASES; phase++) begin
			write_limit(LIMIT_PLAN[phase]);
			rx_mode        = rx_mode_t'(phase % 3);
			stall_pattern  = 8'($urandom_range(1, 255));
			sender_gaps_on = (phase % 4 != 1);
			// back pressure: result side parks while items keep coming
			if (phase == 3)
				hold_req = 1'b1;
			repeat (ITEMS_PER_PHASE) begin
				op = ($urandom_range(0, 99) < FILL_PLAN[phase]) ? OP_INSERT : OP_REMOVE;
				send_item(op, pick_key(), PAYLOAD_BITS'($urandom_range(0, 255)));
			end
		end

		// all words back, then a few quiet cycles for anything stray
		wait_results_drained();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (mismatch_total == 0)
			$display("tb_sorted_priority_queue_unit: clean");
		else
			$display("tb_sorted_priority_queue_unit: errors");
		$finish;
	end

endmodule

// File: sorted_priority_queue_unit.f
hdl/spq_pkg.sv
hdl/spq_ifs.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_unit.sv
dv/spq_result_checker.sv
dv/tb_sorted_priority_queue_unit.sv
